>>> design/owm_pkg.sv
// Shared types, codes and timing constants of the single-wire bus master.
`timescale 1ns / 1ps

package owm_pkg;

   // Number of bus lines that accept commands
   localparam int OWM_PORTS = 4;

   // Width of the slot timer
   localparam int WAIT_WIDTH = 11;

   // Request kinds
   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_RESET = 2'd1,
      KIND_BIT   = 2'd2,
      KIND_BYTE  = 2'd3
   } owm_kind_type;

   // Slot sequencer phases, one-hot
   typedef enum logic [7:0] {
      PH_IDLE    = 8'b0000_0001,
      PH_SLOT_LO = 8'b0000_0010,
      PH_RD_WAIT = 8'b0000_0100,
      PH_RD_POST = 8'b0000_1000,
      PH_WR_REC  = 8'b0001_0000,
      PH_RST_LO  = 8'b0010_0000,
      PH_RST_REL = 8'b0100_0000,
      PH_RST_END = 8'b1000_0000
   } owm_phase_type;

   // Names of the timing intervals
   typedef enum logic [2:0] {
      T_A = 3'd0,
      T_C = 3'd1,
      T_D = 3'd2,
      T_E = 3'd3,
      T_F = 3'd4,
      T_H = 3'd5,
      T_I = 3'd6,
      T_J = 3'd7
   } owm_timing_type;

   // Interval lengths in quarter-microsecond ticks: standard row, then overdrive row
   localparam logic [WAIT_WIDTH-1:0] OWM_TICKS [2][8] = '{
      '{11'd24, 11'd240, 11'd40, 11'd36, 11'd220, 11'd1920, 11'd280, 11'd1640},
      '{11'd6,  11'd30,  11'd10, 11'd3,  11'd28,  11'd10,   11'd34,  11'd160}
   };

   // One result, highest field first
   typedef struct packed {
      logic       echo_match;
      logic [7:0] read_data;
      logic       presence;
      logic       done_res;
      logic       busy_res;
      logic [1:0] active_port;
      logic       drive_low;
   } owm_result_type;

   localparam int RESULT_WIDTH = $bits(owm_result_type);

endpackage

>>> design/owm_seq.sv
// Slot sequencer: phase, slot timer and shift registers, updated once per request.
`timescale 1ns / 1ps

module owm_seq
   import owm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  owm_kind_type   kind,
   input  logic [1:0]     port,
   input  logic [7:0]     send_data,
   input  logic           line_level,
   input  logic           overdrive,
   output owm_result_type result
);

   owm_phase_type         phase_ff, phase_in;
   logic [WAIT_WIDTH-1:0] wait_count_ff, wait_count_in;
   logic [3:0]            bits_left_ff, bits_left_in;
   logic [7:0]            send_shift_ff, send_shift_in;
   logic [7:0]            recv_shift_ff, recv_shift_in;
   logic [1:0]            current_port_ff, current_port_in;
   logic                  presence_ff, presence_in;
   logic                  byte_op_ff, byte_op_in;

   logic                  done;
   logic                  busy;
   logic                  rbit;
   logic                  port_ok;
   logic [7:0]            rec_send;
   logic [7:0]            rec_recv;
   logic [3:0]            rec_bits;
   logic [7:0]            new_send;

   // Hold the sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         wait_count_ff   <= '0;
         bits_left_ff    <= '0;
         send_shift_ff   <= '0;
         recv_shift_ff   <= '0;
         current_port_ff <= '0;
         presence_ff     <= 1'b0;
         byte_op_ff      <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         wait_count_ff   <= wait_count_in;
         bits_left_ff    <= bits_left_in;
         send_shift_ff   <= send_shift_in;
         recv_shift_ff   <= recv_shift_in;
         current_port_ff <= current_port_in;
         presence_ff     <= presence_in;
         byte_op_ff      <= byte_op_in;
      end
   end

   // Bit capture at the end of a slot: shift for a byte, replace for a single bit
   always_comb begin
      rbit     = (phase_ff == PH_RD_WAIT) ? line_level : 1'b0;
      rec_send = byte_op_ff ? {send_shift_ff[0], send_shift_ff[7:1]} : send_shift_ff;
      rec_recv = byte_op_ff ? {rbit, recv_shift_ff[7:1]} : {7'b0, rbit};
      rec_bits = (bits_left_ff != 4'd0) ? bits_left_ff - 4'd1 : bits_left_ff;
      port_ok  = ({30'b0, port} < 32'(OWM_PORTS));
      new_send = (kind == KIND_BYTE) ? send_data : {7'b0, send_data[0]};
   end

   // Advance the sequencer for one accepted request
   always_comb begin
      phase_in        = phase_ff;
      wait_count_in   = wait_count_ff;
      bits_left_in    = bits_left_ff;
      send_shift_in   = send_shift_ff;
      recv_shift_in   = recv_shift_ff;
      current_port_in = current_port_ff;
      presence_in     = presence_ff;
      byte_op_in      = byte_op_ff;
      done            = 1'b0;

      if (accept) begin
         if (phase_ff == PH_IDLE) begin
            // Start a command on a valid line; drop ticks and bad lines
            if (kind != KIND_TICK && port_ok) begin
               current_port_in = port;
               if (kind == KIND_RESET) begin
                  phase_in      = PH_RST_LO;
                  wait_count_in = OWM_TICKS[overdrive][T_H];
               end else begin
                  recv_shift_in = '0;
                  byte_op_in    = (kind == KIND_BYTE);
                  bits_left_in  = (kind == KIND_BYTE) ? 4'd8 : 4'd1;
                  send_shift_in = new_send;
                  phase_in      = PH_SLOT_LO;
                  wait_count_in = new_send[0] ? OWM_TICKS[overdrive][T_A]
                                              : OWM_TICKS[overdrive][T_C];
               end
            end
         end else if (kind == KIND_TICK) begin
            if (wait_count_ff > WAIT_WIDTH'(1)) begin
               wait_count_in = wait_count_ff - WAIT_WIDTH'(1);
            end else begin
               unique case (phase_ff) inside
                  PH_SLOT_LO: begin
                     if (send_shift_ff[0]) begin
                        phase_in      = PH_RD_WAIT;
                        wait_count_in = OWM_TICKS[overdrive][T_E];
                     end else begin
                        send_shift_in = rec_send;
                        recv_shift_in = rec_recv;
                        bits_left_in  = rec_bits;
                        phase_in      = PH_WR_REC;
                        wait_count_in = OWM_TICKS[overdrive][T_D];
                     end
                  end
                  PH_RD_WAIT: begin
                     send_shift_in = rec_send;
                     recv_shift_in = rec_recv;
                     bits_left_in  = rec_bits;
                     phase_in      = PH_RD_POST;
                     wait_count_in = OWM_TICKS[overdrive][T_F];
                  end
                  PH_RD_POST, PH_WR_REC: begin
                     // Next slot of a byte, or finish
                     if (bits_left_ff != 4'd0) begin
                        phase_in      = PH_SLOT_LO;
                        wait_count_in = send_shift_ff[0] ? OWM_TICKS[overdrive][T_A]
                                                         : OWM_TICKS[overdrive][T_C];
                     end else begin
                        phase_in = PH_IDLE;
                        done     = 1'b1;
                     end
                  end
                  PH_RST_LO: begin
                     phase_in      = PH_RST_REL;
                     wait_count_in = OWM_TICKS[overdrive][T_I];
                  end
                  PH_RST_REL: begin
                     // A low line at the sample point is a presence pulse
                     presence_in   = ~line_level;
                     phase_in      = PH_RST_END;
                     wait_count_in = OWM_TICKS[overdrive][T_J];
                  end
                  PH_RST_END: begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
         end
      end
   end

   // Build the result from the updated state
   always_comb begin
      busy               = (phase_in != PH_IDLE);
      result.drive_low   = (phase_in == PH_SLOT_LO) || (phase_in == PH_RST_LO);
      result.active_port = current_port_in;
      result.busy_res    = busy;
      result.done_res    = done;
      result.presence    = presence_in;
      result.read_data   = busy ? 8'd0 : recv_shift_in;
      result.echo_match  = !busy && (recv_shift_in == send_shift_in);
   end

endmodule

>>> design/owm_out_buf.sv
// Two-entry result buffer between the sequencer and the result channel.
`timescale 1ns / 1ps

module owm_out_buf
   import owm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  owm_result_type push_data,
   output logic           can_push,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output owm_result_type rsp_data
);

   owm_result_type entry_ff [2];
   logic [1:0]     count_ff, count_in;
   logic           wr_ptr_ff;
   logic           rd_ptr_ff;
   logic           pop;

   assign pop       = rsp_valid && rsp_ready;
   assign can_push  = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = entry_ff[rd_ptr_ff];

   // Track the fill level
   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   // Advance the pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   // Store a new result
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/one_wire_bus_master.sv
// Top level of the single-wire bus master: speed register, sequencer and result buffer.
`timescale 1ns / 1ps

// Single-wire bus master advanced by quarter-microsecond tick requests. Every
// request (tick or command) yields exactly one result carrying the line drive,
// the active line, busy/done flags, presence and the last touch result. A request
// is taken every cycle while a buffer entry is free: the slot sequencer updates its
// phase, timer and shift registers in the cycle of acceptance, and the result enters
// a two-entry buffer, so the block keeps one request per cycle while the result side
// takes results as fast; it stops taking requests only when both buffer entries wait.
// Results appear in the cycle after their request at the earliest. Commands
// arriving while a sequence runs are dropped. The speed register applies to each
// phase as it begins.
module one_wire_bus_master
   import owm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Speed register
   input  logic        csr_we,
   input  logic        csr_wdata,     // overdrive_mode
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,     // port[1:0], send_data[9:2], line_level[10], zero
   input  logic [1:0]  req_tuser,     // kind[1:0]
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata      // drive_low[0], active_port[2:1], busy_res[3],
                                      // done_res[4], presence[5], read_data[13:6],
                                      // echo_match[14], zero
);

   logic           overdrive_ff;
   logic           accept;
   owm_result_type seq_result;
   owm_result_type buf_result;

   assign accept = req_tvalid && req_tready;

   // Hold the speed selection
   always_ff @(posedge clock) begin
      if (reset) begin
         overdrive_ff <= 1'b0;
      end else if (csr_we) begin
         overdrive_ff <= csr_wdata;
      end
   end

   owm_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .kind       (owm_kind_type'(req_tuser)),
      .port       (req_tdata[1:0]),
      .send_data  (req_tdata[9:2]),
      .line_level (req_tdata[10]),
      .overdrive  (overdrive_ff),
      .result     (seq_result)
   );

   owm_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (seq_result),
      .can_push  (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (buf_result)
   );

   assign rsp_tdata = {{(16 - RESULT_WIDTH){1'b0}}, buf_result};

endmodule

>>> design/owm_checker.sv
// Port-level checks of the single-wire bus master, bound to its top level.
`timescale 1ns / 1ps

module owm_checker (
   input logic        clock,
   input logic        reset,
   input logic        csr_we,
   input logic        csr_wdata,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result payload changed while stalled");

   // Completion is only shown once the sequence has left busy
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |-> !rsp_tdata[3])
      else $error("done shown while busy");

   // Read data and echo flag are cleared while a sequence runs
   a_busy_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> (rsp_tdata[14:6] == 9'd0))
      else $error("read data shown while busy");

   // The line is pulled low only during a sequence
   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[3])
      else $error("line driven while idle");

endmodule

bind one_wire_bus_master owm_checker u_owm_checker (.*);

>>> tb/sv/one_wire_bus_master_test.sv
// Self-checking testbench for the single-wire bus master: directed and random request streams.
`timescale 1ns / 1ps

module one_wire_bus_master_test
   import owm_pkg::*;
();

   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int MAX_IDLE      = 14;
   localparam int HOLD_OFF_LEN  = 200;
   localparam int RANDOM_ITEMS  = 40;
   localparam int RANDOM_CUT    = 40;
   localparam int FULL_SEQUENCE = -1;

   // Line level policy for the ticks of one sequence
   typedef enum int {
      LEVEL_RANDOM = 0,
      LEVEL_HIGH   = 1,
      LEVEL_LOW    = 2
   } level_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic        csr_wdata  = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;     // port[1:0], send_data[9:2], line_level[10], zero
   logic [1:0]  req_tuser  = '0;     // kind[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // drive_low[0], active_port[2:1], busy_res[3],
                                     // done_res[4], presence[5], read_data[13:6],
                                     // echo_match[14], zero

   one_wire_bus_master u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Line model state
   owm_phase_type  seq_phase     = PH_IDLE;
   logic [10:0]    tick_left     = '0;
   logic [3:0]     slots_left    = '0;
   logic [7:0]     tx_shift      = '0;
   logic [7:0]     rx_shift      = '0;
   logic [1:0]     line_sel      = '0;
   logic           presence_seen = 1'b0;
   logic           byte_mode     = 1'b0;
   logic           overdrive_sel = 1'b0;
   owm_kind_type   cmd_kind      = KIND_TICK;

   owm_result_type line_results_due [$];
   owm_result_type got_result;
   owm_result_type want_result;

   // Shared run control and tallies
   bit idle_enable     = 1'b1;
   int hold_off_cycles = 0;
   int error_count     = 0;
   int cycle_count     = 0;
   int requests_sent   = 0;
   int sequences_done  = 0;
   int resets_done     = 0;
   int presence_count  = 0;
   int bits_done       = 0;
   int bytes_done      = 0;
   int echo_count      = 0;

   // ---------------------------------------------------------------- line model

   // Load a phase with its length from the current timing set
   task enter_phase(input owm_phase_type ph, input owm_timing_type which);
      seq_phase = ph;
      tick_left = OWM_TICKS[overdrive_sel][int'(which)];
   endtask

   task start_slot();
      if (tx_shift[0])
         enter_phase(PH_SLOT_LO, T_A);
      else
         enter_phase(PH_SLOT_LO, T_C);
   endtask

   // Shift in one received bit; a byte also rotates the send byte
   task record_bit(input logic rbit);
      if (byte_mode) begin
         tx_shift = {tx_shift[0], tx_shift[7:1]};
         rx_shift = {rbit, rx_shift[7:1]};
      end else begin
         rx_shift = {7'd0, rbit};
      end
      if (slots_left > 0)
         slots_left = slots_left - 4'd1;
   endtask

   // Move past the end of the current phase
   task expire_phase(input logic level, output logic finished);
      finished = 1'b0;
      case (seq_phase)
         PH_SLOT_LO: begin
            if (tx_shift[0]) begin
               enter_phase(PH_RD_WAIT, T_E);
            end else begin
               record_bit(1'b0);
               enter_phase(PH_WR_REC, T_D);
            end
         end
         PH_RD_WAIT: begin
            record_bit(level);
            enter_phase(PH_RD_POST, T_F);
         end
         PH_RD_POST, PH_WR_REC: begin
            if (slots_left > 0) begin
               start_slot();
            end else begin
               seq_phase = PH_IDLE;
               finished  = 1'b1;
            end
         end
         PH_RST_LO: enter_phase(PH_RST_REL, T_I);
         PH_RST_REL: begin
            presence_seen = ~level;
            enter_phase(PH_RST_END, T_J);
         end
         PH_RST_END: begin
            seq_phase = PH_IDLE;
            finished  = 1'b1;
         end
         default: seq_phase = PH_IDLE;
      endcase
   endtask

   // Apply one accepted request and queue the result it must produce
   task advance_line_model(input owm_kind_type kind, input logic [1:0] port,
                           input logic [7:0] data, input logic level);
      owm_result_type due;
      logic           finished;
      logic           busy;
      finished = 1'b0;
      if (seq_phase == PH_IDLE) begin
         if (kind != KIND_TICK && int'(port) < OWM_PORTS) begin
            line_sel = port;
            cmd_kind = kind;
            if (kind == KIND_RESET) begin
               enter_phase(PH_RST_LO, T_H);
            end else begin
               rx_shift = '0;
               if (kind == KIND_BIT) begin
                  byte_mode  = 1'b0;
                  slots_left = 4'd1;
                  tx_shift   = {7'd0, data[0]};
               end else begin
                  byte_mode  = 1'b1;
                  slots_left = 4'd8;
                  tx_shift   = data;
               end
               start_slot();
            end
         end
      end else if (kind == KIND_TICK) begin
         if (tick_left > 11'd1)
            tick_left = tick_left - 11'd1;
         else
            expire_phase(level, finished);
      end

      busy                = (seq_phase != PH_IDLE);
      due.drive_low       = (seq_phase == PH_SLOT_LO || seq_phase == PH_RST_LO);
      due.active_port     = line_sel;
      due.busy_res        = busy;
      due.done_res        = finished;
      due.presence        = presence_seen;
      due.read_data       = busy ? 8'd0 : rx_shift;
      due.echo_match      = !busy && (rx_shift == tx_shift);
      line_results_due.push_back(due);

      // Tally completions for the summary
      if (finished) begin
         sequences_done++;
         if (cmd_kind == KIND_RESET) begin
            resets_done++;
            if (presence_seen)
               presence_count++;
         end else begin
            if (cmd_kind == KIND_BIT)
               bits_done++;
            else
               bytes_done++;
            if (due.echo_match)
               echo_count++;
         end
      end
   endtask

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("t=%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Compare each accepted result with the oldest one due
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_result = owm_result_type'(rsp_tdata[RESULT_WIDTH-1:0]);
         if (line_results_due.size() == 0) begin
            $display("t=%0t: result with none due, expected nothing, actual %h",
                     $time, rsp_tdata);
            error_count++;
         end else begin
            want_result = line_results_due.pop_front();
            check_field("drive_low", 8'(want_result.drive_low), 8'(got_result.drive_low));
            check_field("active_port", 8'(want_result.active_port),
                        8'(got_result.active_port));
            check_field("busy_res", 8'(want_result.busy_res), 8'(got_result.busy_res));
            check_field("done_res", 8'(want_result.done_res), 8'(got_result.done_res));
            check_field("presence", 8'(want_result.presence), 8'(got_result.presence));
            check_field("read_data", want_result.read_data, got_result.read_data);
            check_field("echo_match", 8'(want_result.echo_match),
                        8'(got_result.echo_match));
            check_field("pad", 8'd0, 8'(rsp_tdata[15]));
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Take results, stalling at random and holding off on demand
   initial begin : result_sink
      int stall;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         stall = idle_enable ? $urandom_range(0, MAX_IDLE) : 0;
         if (hold_off_cycles > 0) begin
            stall           = hold_off_cycles;
            hold_off_cycles = 0;
         end
         repeat (stall) begin
            @(negedge clock);
            rsp_tready = 1'b0;
         end
         @(negedge clock);
         rsp_tready = 1'b1;
         forever begin
            @(posedge clock);
            if (rsp_tvalid)
               break;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   // Offer one request after a random gap and hold it until taken
   task automatic send_request(input owm_kind_type kind, input logic [1:0] port,
                               input logic [7:0] data, input logic level);
      int gap;
      gap = idle_enable ? $urandom_range(0, MAX_IDLE) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {5'd0, level, data, port};
      req_tuser  = kind;
      forever begin
         @(posedge clock);
         if (req_tready)
            break;
      end
      advance_line_model(kind, port, data, level);
      requests_sent++;
   endtask

   function automatic logic pick_level(input level_mode_type mode);
      case (mode)
         LEVEL_HIGH: return 1'b1;
         LEVEL_LOW:  return 1'b0;
         default:    return 1'($urandom_range(0, 1));
      endcase
   endfunction

   // Drop valid and wait for every result due
   task automatic drain_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (line_results_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_overdrive(input logic value);
      drain_results();
      @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we        = 1'b0;
      overdrive_sel = value;
   endtask

   // Issue a command, then tick until the line goes idle or the cut is reached
   task automatic run_sequence(input owm_kind_type kind, input logic [1:0] port,
                               input logic [7:0] data, input level_mode_type mode,
                               input bit noise, input int cut);
      int sent;
      sent = 0;
      send_request(kind, port, data, pick_level(mode));
      while (seq_phase != PH_IDLE && sent != cut) begin
         if (noise && $urandom_range(0, 19) == 0)
            send_request(owm_kind_type'($urandom_range(1, 3)), 2'($urandom_range(0, 3)),
                         8'($urandom), pick_level(LEVEL_RANDOM));
         else
            send_request(KIND_TICK, 2'($urandom_range(0, 3)), 8'($urandom), pick_level(mode));
         sent++;
      end
   endtask

   // Ticks on an idle line change nothing
   task automatic test_idle_ticks();
      set_overdrive(1'b1);
      send_request(KIND_TICK, 2'd0, 8'h00, 1'b0);
      send_request(KIND_TICK, 2'd3, 8'hFF, 1'b1);
      send_request(KIND_TICK, 2'd1, 8'hA5, 1'b0);
      send_request(KIND_TICK, 2'd2, 8'h5A, 1'b1);
   endtask

   // Reset with and without presence, with commands dropped while busy
   task automatic test_bus_reset();
      run_sequence(KIND_RESET, 2'd3, 8'hFF, LEVEL_LOW, 1'b1, FULL_SEQUENCE);
      run_sequence(KIND_RESET, 2'd0, 8'h00, LEVEL_HIGH, 1'b0, FULL_SEQUENCE);
   endtask

   // Read slots high and low, write slot
   task automatic test_touch_bits();
      run_sequence(KIND_BIT, 2'd1, 8'h01, LEVEL_HIGH, 1'b0, FULL_SEQUENCE);
      run_sequence(KIND_BIT, 2'd2, 8'hFF, LEVEL_LOW, 1'b0, FULL_SEQUENCE);
      run_sequence(KIND_BIT, 2'd3, 8'h00, LEVEL_HIGH, 1'b1, FULL_SEQUENCE);
   endtask

   // Mixed byte on a line that stays high, so it reads back as sent
   task automatic test_touch_bytes();
      run_sequence(KIND_BYTE, 2'd2, 8'hA5, LEVEL_HIGH, 1'b1, FULL_SEQUENCE);
   endtask

   // Switch timing set part way through a slot, both directions
   task automatic test_speed_change_while_busy();
      // Standard read slot finished at overdrive speed
      set_overdrive(1'b0);
      run_sequence(KIND_BIT, 2'd1, 8'h01, LEVEL_RANDOM, 1'b0, 10);
      set_overdrive(1'b1);
      run_sequence(KIND_TICK, 2'd0, 8'h00, LEVEL_RANDOM, 1'b0, FULL_SEQUENCE);
      // Overdrive write slot finished at standard speed
      run_sequence(KIND_BIT, 2'd2, 8'h00, LEVEL_LOW, 1'b0, 20);
      set_overdrive(1'b0);
      run_sequence(KIND_TICK, 2'd0, 8'h00, LEVEL_RANDOM, 1'b0, FULL_SEQUENCE);
      set_overdrive(1'b1);
   endtask

   // Stall the result side for a long stretch while requests stream in
   task automatic test_result_backpressure();
      idle_enable     = 1'b0;
      hold_off_cycles = HOLD_OFF_LEN;
      run_sequence(KIND_BIT, 2'd2, 8'h01, LEVEL_RANDOM, 1'b0, FULL_SEQUENCE);
      idle_enable     = 1'b1;
   endtask

   // Short random sequences: single bits run to the end, longer ones are cut
   task automatic test_random_sequences();
      int             start_items;
      int             cut;
      logic [7:0]     data;
      owm_kind_type   kind;
      level_mode_type mode;
      start_items = requests_sent;
      while (requests_sent - start_items < RANDOM_ITEMS) begin
         idle_enable = ($urandom_range(0, 3) != 0);
         kind        = owm_kind_type'($urandom_range(1, 3));
         mode        = level_mode_type'($urandom_range(0, 2));
         case ($urandom_range(0, 3))
            0:       data = 8'h00;
            1:       data = 8'hFF;
            default: data = 8'($urandom);
         endcase
         cut = (kind == KIND_BIT) ? FULL_SEQUENCE : $urandom_range(1, RANDOM_CUT);
         run_sequence(kind, 2'($urandom_range(0, 3)), data, mode, 1'b1, cut);
         repeat ($urandom_range(0, 2))
            send_request(KIND_TICK, 2'($urandom_range(0, 3)), 8'($urandom),
                         pick_level(LEVEL_RANDOM));
      end
      idle_enable = 1'b1;
   endtask

   // ---------------------------------------------------------------- sequence of tests

   initial begin
      repeat (12) @(negedge clock);
      reset = 1'b0;

      test_idle_ticks();
      test_bus_reset();
      test_touch_bits();
      test_touch_bytes();
      test_speed_change_while_busy();
      test_result_backpressure();
      test_random_sequences();

      drain_results();
      repeat (10) @(posedge clock);

      $display("Sent %0d requests; %0d resets (%0d with presence), %0d bit and %0d byte touches",
               requests_sent, resets_done, presence_count, bits_done, bytes_done);
      $display("Both timing sets, mid-slot speed changes, dropped commands, %0d echoes, %0d errors",
               echo_count, error_count);
      if (error_count == 0 && line_results_due.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

>>> one_wire_bus_master.f
design/owm_pkg.sv
design/owm_seq.sv
design/owm_out_buf.sv
design/one_wire_bus_master.sv
design/owm_checker.sv
tb/sv/one_wire_bus_master_test.sv
